// ===== hw/rtl/audio_ring_play_cursor_unit_macros.svh =====
// Assertion macros for the audio ring play cursor checker.
// No dependencies; included by the checker file.
`ifndef AUDIO_RING_PLAY_CURSOR_UNIT_MACROS_SVH
`define AUDIO_RING_PLAY_CURSOR_UNIT_MACROS_SVH

// Implication into the next cycle, quiet during reset
`define ARPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Same-cycle implication, quiet during reset
`define ARPC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication into the next cycle that also holds through reset
`define ARPC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/arpc_pkg.sv =====
// Package for the audio ring play cursor: item types, codes, states,
// controller/datapath command and status structs. No dependencies.
package arpc_pkg;

  localparam int CURSOR_BITS_DEF = 24;
  localparam int FIELD_BITS      = 24;
  localparam int LEAD_DIVISOR    = 66;
  localparam int LEAD_BITS       = 20;
  localparam int RATE_BITS       = 26;
  localparam int DIV_N_BITS      = 64;
  localparam int DIV_D_BITS      = 32;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 32;

  // Lead divide by 66: halve, then multiply by ceil(2^31 / 33) and drop
  // 31 bits; exact for every 25-bit halved byte rate
  localparam logic [25:0] LEAD_RECIP = 26'd65075263;
  localparam int          LEAD_SHIFT = 31;

  // Register reset values
  localparam logic [23:0] BUF_RST    = 24'd0;
  localparam logic [7:0]  ALIGN_RST  = 8'd4;
  localparam logic [17:0] FMT_RST    = 18'd22050;
  localparam logic [17:0] PLAY_RST   = 18'd0;
  localparam logic [25:0] AVG_RST    = 26'd88200;
  localparam logic [31:0] TICKR_RST  = 32'd10000000;

  // Configuration register indexes
  localparam logic [2:0] CFG_BUFFER_BYTES = 3'd0;
  localparam logic [2:0] CFG_BLOCK_ALIGN  = 3'd1;
  localparam logic [2:0] CFG_FORMAT_RATE  = 3'd2;
  localparam logic [2:0] CFG_PLAY_RATE    = 3'd3;
  localparam logic [2:0] CFG_AVG_BYTES    = 3'd4;
  localparam logic [2:0] CFG_TICK_RATE    = 3'd5;

  // Command codes
  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_PLAY     = 3'd1;
  localparam logic [2:0] FUNC_STOP     = 3'd2;
  localparam logic [2:0] FUNC_SETPOS   = 3'd3;
  localparam logic [2:0] FUNC_QUERY    = 3'd4;
  localparam logic [2:0] FUNC_LOCK     = 3'd5;
  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] elapsed_ticks;
    logic [31:0] position;
    logic [31:0] lock_bytes;
    logic        loop_flag;
    logic        entire_flag;
    logic        from_cursor_flag;
  } in_item_t;

  typedef struct packed {
    logic [23:0] play_cursor;
    logic [23:0] write_cursor;
    logic        playing;
    logic        looping;
    logic [23:0] region_offset;
    logic [23:0] first_length;
    logic [23:0] second_length;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL, S_TICK_DIV, S_TICK_UPD, S_WRAP_DIV,
    S_POS_DIV, S_LOCK_DIV, S_LEAD, S_ALIGN_DIV, S_WR_DIV, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    DSEL_TICK, DSEL_WRAP, DSEL_SETPOS, DSEL_LOCK, DSEL_ALIGN, DSEL_WRITE
  } div_sel_t;

  typedef struct packed {
    logic     cap;
    logic     rate_ld;
    logic     play_set;
    logic     stop_set;
    logic     pos_zero;
    logic     mul_ld;
    logic     div_start;
    div_sel_t div_sel;
    logic     tick_take;
    logic     tick_upd;
    logic     wrap_take;
    logic     pos_take;
    logic     lock_take;
    logic     lead_take;
    logic     align_take;
    logic     wr_take;
    logic     out_ld;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       tick_active;
    logic       wrap;
    logic       buf_zero;
    logic       align_zero;
    logic       div_busy;
    logic       div_done;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/arpc_if.sv =====
// Valid/ready channel interfaces for the play cursor's items.
// Depends on arpc_pkg for the item types.
interface arpc_in_if;
  logic                valid;
  logic                ready;
  arpc_pkg::in_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface arpc_out_if;
  logic                valid;
  logic                ready;
  arpc_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hw/rtl/arpc_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit.
// Depends on arpc_pkg for widths.
module arpc_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [arpc_pkg::DIV_N_BITS-1:0]    dividend,
  input  logic [arpc_pkg::DIV_D_BITS-1:0]    divisor,
  output logic                               busy,
  output logic                               done,
  output logic [arpc_pkg::DIV_N_BITS-1:0]    quo,
  output logic [arpc_pkg::DIV_D_BITS-1:0]    rem
);
  localparam int NB = arpc_pkg::DIV_N_BITS;
  localparam int DB = arpc_pkg::DIV_D_BITS;
  localparam int CB = $clog2(NB);

  logic [CB-1:0] cnt;
  logic [DB:0]   shifted;
  logic [DB:0]   diff;
  logic          take;
  logic [DB-1:0] dsr;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    shifted = {rem, quo[NB-1]};
    diff    = shifted - {1'b0, dsr};
    take    = (shifted >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CB'(NB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient and partial remainder
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= take ? diff[DB-1:0] : shifted[DB-1:0];
      quo <= {quo[NB-2:0], take};
    end
  end
endmodule

// ===== hw/rtl/arpc_datapath.sv =====
// Datapath of the play cursor: configuration, cursor state, multiplier,
// shared divider and the output register. Depends on arpc_pkg, arpc_div.
module arpc_datapath #(
  parameter int CURSOR_BITS = arpc_pkg::CURSOR_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [arpc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [arpc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  arpc_pkg::in_item_t                   in_item,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output arpc_pkg::out_item_t                  out_item,
  input  arpc_pkg::ctrl_cmd_t                  cmd,
  output arpc_pkg::dp_status_t                 status
);
  localparam int LB = arpc_pkg::LEAD_BITS;
  localparam int RB = arpc_pkg::RATE_BITS;
  localparam int NB = arpc_pkg::DIV_N_BITS;
  localparam int DB = arpc_pkg::DIV_D_BITS;

  // Configuration registers
  logic [23:0] buffer_bytes;
  logic [7:0]  block_align;
  logic [17:0] format_rate;
  logic [17:0] play_rate;
  logic [25:0] avg_bytes_per_sec;
  logic [31:0] tick_rate;

  // Cursor state
  logic [CURSOR_BITS-1:0] cursor;
  logic [31:0]            remq;
  logic                   playing;
  logic                   looping;

  // Work registers
  arpc_pkg::in_item_t item;
  logic [RB-1:0]      rate;
  logic [NB-1:0]      total;
  logic [NB-1:0]      pos;
  logic [LB-1:0]      lead;
  logic [23:0]        wr;
  logic [23:0]        reg_off;
  logic [23:0]        reg_first;
  logic [23:0]        reg_second;

  // Divider port
  logic [NB-1:0] div_n;
  logic [DB-1:0] div_d;
  logic          div_busy;
  logic          div_done;
  logic [NB-1:0] div_quo;
  logic [DB-1:0] div_rem;

  logic [17:0]   rate_sel;
  logic [57:0]   prod;
  logic [50:0]   lead_prod;
  logic [31:0]   lock_off;
  logic [31:0]   lock_len;
  logic [23:0]   len_sat;
  logic [23:0]   off_red;
  logic [23:0]   first_len;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes      <= arpc_pkg::BUF_RST;
      block_align       <= arpc_pkg::ALIGN_RST;
      format_rate       <= arpc_pkg::FMT_RST;
      play_rate         <= arpc_pkg::PLAY_RST;
      avg_bytes_per_sec <= arpc_pkg::AVG_RST;
      tick_rate         <= arpc_pkg::TICKR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        arpc_pkg::CFG_BUFFER_BYTES: buffer_bytes      <= cfg_data[23:0];
        arpc_pkg::CFG_BLOCK_ALIGN:  block_align       <= cfg_data[7:0];
        arpc_pkg::CFG_FORMAT_RATE:  format_rate       <= cfg_data[17:0];
        arpc_pkg::CFG_PLAY_RATE:    play_rate         <= cfg_data[17:0];
        arpc_pkg::CFG_AVG_BYTES:    avg_bytes_per_sec <= cfg_data[25:0];
        arpc_pkg::CFG_TICK_RATE:    tick_rate         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Rate, product, lead and lock operands
  always_comb begin
    rate_sel = (play_rate != 18'd0) ? play_rate : format_rate;
    prod     = rate * item.elapsed_ticks;
    lead_prod = 51'(avg_bytes_per_sec[25:1]) * 51'(arpc_pkg::LEAD_RECIP);
    lock_off = item.entire_flag ? 32'd0 : item.position;
    if (item.from_cursor_flag) lock_off = 32'(cursor);
    lock_len = item.entire_flag ? 32'(buffer_bytes) : item.lock_bytes;
    len_sat  = (lock_len > 32'(buffer_bytes)) ? buffer_bytes : lock_len[23:0];
    off_red  = div_rem[23:0];
    first_len = (({1'b0, off_red} + {1'b0, len_sat}) > {1'b0, buffer_bytes}) ?
                (buffer_bytes - off_red) : len_sat;
  end

  // Select divider operands
  always_comb begin
    case (cmd.div_sel)
      arpc_pkg::DSEL_TICK:   begin div_n = total;                  div_d = tick_rate; end
      arpc_pkg::DSEL_WRAP:   begin div_n = pos;                    div_d = DB'(buffer_bytes); end
      arpc_pkg::DSEL_SETPOS: begin div_n = NB'(item.position);     div_d = DB'(buffer_bytes); end
      arpc_pkg::DSEL_LOCK:   begin div_n = NB'(lock_off);          div_d = DB'(buffer_bytes); end
      arpc_pkg::DSEL_ALIGN:  begin div_n = NB'(lead);              div_d = DB'(block_align); end
      arpc_pkg::DSEL_WRITE:  begin div_n = NB'(cursor) + NB'(lead); div_d = DB'(buffer_bytes); end
      default:               begin div_n = total;                  div_d = tick_rate; end
    endcase
  end

  arpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Cursor and play state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor  <= '0;
      remq    <= '0;
      playing <= 1'b0;
      looping <= 1'b0;
    end else begin
      if (cmd.play_set) begin
        playing <= 1'b1;
        looping <= item.loop_flag;
      end
      if (cmd.stop_set) playing <= 1'b0;
      if (cmd.pos_zero) begin
        cursor <= '0;
        remq   <= '0;
      end
      if (cmd.tick_take) remq <= div_rem;
      if (cmd.tick_upd) begin
        if (pos >= NB'(buffer_bytes)) begin
          if (!looping) begin
            cursor  <= '0;
            remq    <= '0;
            playing <= 1'b0;
          end
        end else begin
          cursor <= pos[CURSOR_BITS-1:0];
        end
      end
      if (cmd.wrap_take) cursor <= div_rem[CURSOR_BITS-1:0];
      if (cmd.pos_take) begin
        cursor <= div_rem[CURSOR_BITS-1:0];
        remq   <= '0;
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      item       <= in_item;
      reg_off    <= '0;
      reg_first  <= '0;
      reg_second <= '0;
    end
    if (cmd.rate_ld)   rate  <= RB'(block_align) * RB'(rate_sel);
    if (cmd.mul_ld)    total <= NB'(prod) + NB'(remq);
    if (cmd.tick_take) pos   <= NB'(cursor) + div_quo;
    if (cmd.lock_take) begin
      reg_off    <= off_red;
      reg_first  <= first_len;
      reg_second <= len_sat - first_len;
    end
    if (cmd.lead_take)  lead <= lead_prod[arpc_pkg::LEAD_SHIFT +: LB];
    if (cmd.align_take) lead <= lead - div_rem[LB-1:0];
    if (cmd.wr_take)    wr   <= div_rem[23:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_item.play_cursor   <= 24'(cursor);
      out_item.write_cursor  <= (buffer_bytes == 24'd0) ? 24'd0 : wr;
      out_item.playing       <= playing;
      out_item.looping       <= looping;
      out_item.region_offset <= reg_off;
      out_item.first_length  <= reg_first;
      out_item.second_length <= reg_second;
    end
  end

  // Status to the controller
  always_comb begin
    status.func        = item.func;
    status.tick_active = playing && (buffer_bytes != 24'd0) &&
                         (item.elapsed_ticks != 32'd0) && (tick_rate != 32'd0);
    status.wrap        = (pos >= NB'(buffer_bytes)) && looping;
    status.buf_zero    = (buffer_bytes == 24'd0);
    status.align_zero  = (block_align == 8'd0);
    status.div_busy    = div_busy;
    status.div_done    = div_done;
    status.out_free    = !out_valid || out_ready;
  end
endmodule

// ===== hw/rtl/arpc_ctrl.sv =====
// Controller state machine of the play cursor: sequences the multiply,
// the divides and the result load. Depends on arpc_pkg.
module arpc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  arpc_pkg::dp_status_t  status,
  output arpc_pkg::ctrl_cmd_t   cmd
);
  arpc_pkg::state_t state;
  arpc_pkg::state_t state_next;
  logic             start_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arpc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      arpc_pkg::S_IDLE: begin
        if (in_valid) state_next = arpc_pkg::S_DECODE;
      end
      arpc_pkg::S_DECODE: begin
        case (status.func)
          arpc_pkg::FUNC_TICK:
            state_next = status.tick_active ? arpc_pkg::S_MUL : arpc_pkg::S_LEAD;
          arpc_pkg::FUNC_SETPOS:
            state_next = status.buf_zero ? arpc_pkg::S_LEAD : arpc_pkg::S_POS_DIV;
          arpc_pkg::FUNC_LOCK:
            state_next = status.buf_zero ? arpc_pkg::S_LEAD : arpc_pkg::S_LOCK_DIV;
          default: state_next = arpc_pkg::S_LEAD;
        endcase
      end
      arpc_pkg::S_MUL: state_next = arpc_pkg::S_TICK_DIV;
      arpc_pkg::S_TICK_DIV: begin
        if (status.div_done) state_next = arpc_pkg::S_TICK_UPD;
      end
      arpc_pkg::S_TICK_UPD:
        state_next = status.wrap ? arpc_pkg::S_WRAP_DIV : arpc_pkg::S_LEAD;
      arpc_pkg::S_WRAP_DIV, arpc_pkg::S_POS_DIV, arpc_pkg::S_LOCK_DIV: begin
        if (status.div_done) state_next = arpc_pkg::S_LEAD;
      end
      arpc_pkg::S_LEAD: begin
        if (!status.align_zero)    state_next = arpc_pkg::S_ALIGN_DIV;
        else if (status.buf_zero)  state_next = arpc_pkg::S_OUT;
        else                       state_next = arpc_pkg::S_WR_DIV;
      end
      arpc_pkg::S_ALIGN_DIV: begin
        if (status.div_done)
          state_next = status.buf_zero ? arpc_pkg::S_OUT : arpc_pkg::S_WR_DIV;
      end
      arpc_pkg::S_WR_DIV: begin
        if (status.div_done) state_next = arpc_pkg::S_OUT;
      end
      arpc_pkg::S_OUT: begin
        if (status.out_free) state_next = arpc_pkg::S_IDLE;
      end
      default: state_next = arpc_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.div_sel = arpc_pkg::DSEL_TICK;
    start_ok = !status.div_busy && !status.div_done;
    in_ready = (state == arpc_pkg::S_IDLE);
    case (state)
      arpc_pkg::S_IDLE: cmd.cap = in_valid;
      arpc_pkg::S_DECODE: begin
        cmd.rate_ld  = (status.func == arpc_pkg::FUNC_TICK);
        cmd.play_set = (status.func == arpc_pkg::FUNC_PLAY);
        cmd.stop_set = (status.func == arpc_pkg::FUNC_STOP);
        cmd.pos_zero = (status.func == arpc_pkg::FUNC_SETPOS) && status.buf_zero;
      end
      arpc_pkg::S_MUL: cmd.mul_ld = 1'b1;
      arpc_pkg::S_TICK_DIV: begin
        cmd.div_sel   = arpc_pkg::DSEL_TICK;
        cmd.div_start = start_ok;
        cmd.tick_take = status.div_done;
      end
      arpc_pkg::S_TICK_UPD: cmd.tick_upd = 1'b1;
      arpc_pkg::S_WRAP_DIV: begin
        cmd.div_sel   = arpc_pkg::DSEL_WRAP;
        cmd.div_start = start_ok;
        cmd.wrap_take = status.div_done;
      end
      arpc_pkg::S_POS_DIV: begin
        cmd.div_sel   = arpc_pkg::DSEL_SETPOS;
        cmd.div_start = start_ok;
        cmd.pos_take  = status.div_done;
      end
      arpc_pkg::S_LOCK_DIV: begin
        cmd.div_sel   = arpc_pkg::DSEL_LOCK;
        cmd.div_start = start_ok;
        cmd.lock_take = status.div_done;
      end
      arpc_pkg::S_LEAD: cmd.lead_take = 1'b1;
      arpc_pkg::S_ALIGN_DIV: begin
        cmd.div_sel    = arpc_pkg::DSEL_ALIGN;
        cmd.div_start  = start_ok;
        cmd.align_take = status.div_done;
      end
      arpc_pkg::S_WR_DIV: begin
        cmd.div_sel   = arpc_pkg::DSEL_WRITE;
        cmd.div_start = start_ok;
        cmd.wr_take   = status.div_done;
      end
      arpc_pkg::S_OUT: cmd.out_ld = status.out_free;
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/audio_ring_play_cursor_unit.sv =====
// Top level of the audio ring play cursor: controller plus datapath.
// Depends on arpc_pkg, arpc_if, arpc_ctrl, arpc_datapath.
//
//   channel  | dir | handshake     | payload
//   cfg      | in  | cfg_we        | cfg_index, cfg_data
//   in_ch    | in  | valid / ready | arpc_pkg::in_item_t
//   out_ch   | out | valid / ready | arpc_pkg::out_item_t
//
// One item at a time; each divide on the shared 64-step divider runs a start,
// 64 steps and a done. An item needs zero to four divides (a looping tick that
// wraps, with a nonzero block align, needs four), and an active tick also passes
// the multiply and update states; the controller then returns to idle. The
// write lead is a reciprocal multiply, registered in the lead state. Reset is synchronous.
// A new item is taken while the previous result waits in the output register;
// a stalled output holds the controller in its last state before it can
// load the next result.
module audio_ring_play_cursor_unit #(
  parameter int CURSOR_BITS = arpc_pkg::CURSOR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [arpc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [arpc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  arpc_in_if.sink                             in_ch,
  arpc_out_if.source                          out_ch
);
  arpc_pkg::ctrl_cmd_t  cmd;
  arpc_pkg::dp_status_t status;

  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  arpc_datapath #(.CURSOR_BITS(CURSOR_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_ch.item),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_item  (out_ch.item),
    .cmd       (cmd),
    .status    (status)
  );
endmodule

// ===== hw/rtl/arpc_checker.sv =====
// Port-level checks for the play cursor, bound to the top level.
// Depends on arpc_pkg and audio_ring_play_cursor_unit_macros.svh.
`include "audio_ring_play_cursor_unit_macros.svh"

module arpc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input arpc_pkg::out_item_t out_item
);
  // Hold a stalled result
  `ARPC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ARPC_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_item))
  // Nothing pending right after reset
  `ARPC_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !out_valid)
  // One item in work at a time
  `ARPC_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)
  // A wrapped lock tail implies a nonempty first region
  `ARPC_ASSERT_SAME(a_lock_split, clk, rst,
    out_valid && (out_item.second_length != 24'd0), out_item.first_length != 24'd0)
endmodule

bind audio_ring_play_cursor_unit arpc_checker u_arpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.item)
);
